/* hdl/assert_macros.svh */
// Assertion macros used by the ALU top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/sca_pkg.sv */
// Package with the types, codes and helpers of the saturating checked ALU.
`default_nettype none

package sca_pkg;

	localparam int unsigned MAX_WIDTH  = 64;
	localparam int unsigned NARROW     = 32;
	localparam int unsigned HALF       = MAX_WIDTH / 2;
	localparam int unsigned DIV_STAGES = MAX_WIDTH;
	// The side data leaves stage 5 and must meet the quotient after the divider.
	localparam int unsigned SIDE_DELAY = DIV_STAGES - 3;

	typedef logic [MAX_WIDTH-1:0] word_t;
	typedef logic [2:0]           status_t;
	typedef logic [1:0]           op_t;
	typedef logic [1:0]           mode_t;

	localparam op_t OP_ADD = 2'd0;
	localparam op_t OP_SUB = 2'd1;
	localparam op_t OP_MUL = 2'd2;
	localparam op_t OP_DIV = 2'd3;

	localparam status_t ST_OK       = 3'd0;
	localparam status_t ST_OVF_HI   = 3'd1;
	localparam status_t ST_OVF_LO   = 3'd2;
	localparam status_t ST_DIV_ZERO = 3'd3;
	localparam status_t ST_DIV_OVF  = 3'd4;

	localparam mode_t MODE_SILENT = 2'd0;
	localparam mode_t MODE_REPORT = 2'd1;
	localparam mode_t MODE_TRAP   = 2'd2;

	// Per-beat data that travels alongside the divider.
	typedef struct packed {
		logic    valid;
		logic    wide;
		logic    is_div;
		logic    qneg;
		word_t   res;
		status_t st;
	} side_t;

	// Mask of the active width.
	function automatic word_t width_mask(input logic wide);
		word_t m;
		m = '0;
		m[NARROW-1:0] = '1;
		if (wide) begin
			m = '1;
		end
		return m;
	endfunction

	// Sign bit of the active width, alone in its place.
	function automatic word_t sign_bit(input logic wide);
		word_t s;
		s = '0;
		if (wide) begin
			s[MAX_WIDTH-1] = 1'b1;
		end else begin
			s[NARROW-1] = 1'b1;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

/* hdl/sca_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module sca_div (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire sca_pkg::word_t dvd,
	input  wire sca_pkg::word_t dvs,
	output sca_pkg::word_t      quo
);

	localparam int unsigned W = sca_pkg::MAX_WIDTH;
	localparam int unsigned N = sca_pkg::DIV_STAGES;

	sca_pkg::word_t dvd_p [0:N];
	sca_pkg::word_t dvs_p [0:N];
	sca_pkg::word_t quo_p [0:N];
	sca_pkg::word_t rem_p [0:N];

	assign dvd_p[0] = dvd;
	assign dvs_p[0] = dvs;
	assign quo_p[0] = '0;
	assign rem_p[0] = '0;

	// Each stage shifts in one dividend bit and tries one subtraction.
	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [W:0]   shifted;
		logic [W+1:0] trial;
		logic         ge;

		assign shifted = {rem_p[k], dvd_p[k][W-1]};
		assign trial   = {1'b0, shifted} - {2'b00, dvs_p[k]};
		assign ge      = !trial[W+1];

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k+1] <= ge ? trial[W-1:0] : shifted[W-1:0];
				dvd_p[k+1] <= {dvd_p[k][W-2:0], 1'b0};
				dvs_p[k+1] <= dvs_p[k];
				quo_p[k+1] <= {quo_p[k][W-2:0], ge};
			end
		end
	end

	assign quo = quo_p[N];

endmodule

`default_nettype wire

/* hdl/saturating_checked_int_alu_top.sv */
// Top level of the saturating checked integer ALU.
//
// Input channel: in_valid/in_stall with operation, is_signed, wide, lhs, rhs.
// A beat is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with result, status, fatal; a beat is
// delivered at a rising edge with out_valid high and out_stall low.
// Configuration: error_mode is written at any edge with error_mode_we high.
// Every operation passes through the same pipeline depth from input beat to output beat;
// the depth is set by the 64-stage divider, one quotient bit per stage.
// Throughput is one beat per cycle unless stalled. Add, subtract and multiply
// results ride a delay line next to the divider so all beats leave in order.
// When the receiver stalls a waiting output beat, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits and sets error_mode to silent saturation.
// Narrow beats use the low 32 bits and return zero-extended results.
`default_nettype none

`include "assert_macros.svh"

module saturating_checked_int_alu_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                error_mode_we,
	input  wire sca_pkg::mode_t      error_mode,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire sca_pkg::op_t        operation,
	input  wire logic                is_signed,
	input  wire logic                wide,
	input  wire sca_pkg::word_t      lhs,
	input  wire sca_pkg::word_t      rhs,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sca_pkg::word_t           result,
	output sca_pkg::status_t         status,
	output logic                     fatal
);

	localparam int unsigned W = sca_pkg::MAX_WIDTH;
	localparam int unsigned H = sca_pkg::HALF;
	localparam int unsigned D = sca_pkg::SIDE_DELAY;

	logic en;
	sca_pkg::mode_t mode_q;

	// Output registers.
	logic             out_valid_q;
	sca_pkg::word_t   result_q;
	sca_pkg::status_t status_q;
	logic             fatal_q;
	logic             wide_q;

	assign in_stall  = out_valid_q && out_stall;
	assign en        = !in_stall;
	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;
	assign fatal     = fatal_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sca_pkg::MODE_SILENT;
		end else if (error_mode_we) begin
			mode_q <= error_mode;
		end
	end

	// Stage 1: capture the beat with operands masked to the width.
	logic           v_s1, sgn_s1, wide_s1;
	sca_pkg::op_t   op_s1;
	sca_pkg::word_t a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= operation;
			sgn_s1  <= is_signed;
			wide_s1 <= wide;
			a_s1    <= lhs & sca_pkg::width_mask(wide);
			b_s1    <= rhs & sca_pkg::width_mask(wide);
		end
	end

	// Stage 2: magnitudes, add/subtract and the divide special cases.
	sca_pkg::word_t   mask1, sbit1, smax1, ma1, mb1, t1, as_res1, dz_res1;
	logic             an1, bn1, tn1, bx1, cout1, bz1;
	logic [W:0]       sum1;
	sca_pkg::status_t as_st1, dz_st1;

	always_comb begin
		mask1 = sca_pkg::width_mask(wide_s1);
		sbit1 = sca_pkg::sign_bit(wide_s1);
		smax1 = sbit1 - W'(1);
		an1   = |(a_s1 & sbit1);
		bn1   = |(b_s1 & sbit1);
		ma1   = (sgn_s1 && an1) ? ((-a_s1) & mask1) : a_s1;
		mb1   = (sgn_s1 && bn1) ? ((-b_s1) & mask1) : b_s1;
		sum1  = (op_s1 == sca_pkg::OP_ADD) ? ({1'b0, a_s1} + {1'b0, b_s1})
			: ({1'b0, a_s1} - {1'b0, b_s1});
		t1    = sum1[W-1:0] & mask1;
		tn1   = |(t1 & sbit1);
		bx1   = (op_s1 == sca_pkg::OP_SUB) ? !bn1 : bn1;
		cout1 = wide_s1 ? sum1[W] : sum1[sca_pkg::NARROW];
		as_res1 = t1;
		as_st1  = sca_pkg::ST_OK;
		if (sgn_s1) begin
			if (!an1 && !bx1 && tn1) begin
				as_res1 = smax1;
				as_st1  = sca_pkg::ST_OVF_HI;
			end else if (an1 && bx1 && !tn1) begin
				as_res1 = sbit1;
				as_st1  = sca_pkg::ST_OVF_LO;
			end
		end else if (op_s1 == sca_pkg::OP_ADD) begin
			if (cout1) begin
				as_res1 = mask1;
				as_st1  = sca_pkg::ST_OVF_HI;
			end
		end else if (a_s1 < b_s1) begin
			as_res1 = '0;
			as_st1  = sca_pkg::ST_OVF_LO;
		end
		// Division by zero and signed MIN over minus one bypass the divider.
		bz1     = (b_s1 == '0);
		dz_res1 = '0;
		dz_st1  = sca_pkg::ST_OK;
		if (bz1) begin
			dz_res1 = sgn_s1 ? a_s1 : mask1;
			dz_st1  = sca_pkg::ST_DIV_ZERO;
		end else if (sgn_s1 && a_s1 == sbit1 && b_s1 == mask1) begin
			dz_res1 = a_s1;
			dz_st1  = sca_pkg::ST_DIV_OVF;
		end
	end

	logic             v_s2, sgn_s2, wide_s2, neg_s2;
	sca_pkg::op_t     op_s2;
	sca_pkg::word_t   ma_s2, mb_s2, as_res_s2, dz_res_s2;
	sca_pkg::status_t as_st_s2, dz_st_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2     <= op_s1;
			sgn_s2    <= sgn_s1;
			wide_s2   <= wide_s1;
			neg_s2    <= sgn_s1 && (an1 ^ bn1);
			ma_s2     <= ma1;
			mb_s2     <= mb1;
			as_res_s2 <= as_res1;
			as_st_s2  <= as_st1;
			dz_res_s2 <= dz_res1;
			dz_st_s2  <= dz_st1;
		end
	end

	// Divider on the magnitudes, aligned with the end of the delay line.
	sca_pkg::word_t quo;

	sca_div u_div (
		.clk (clk),
		.en  (en),
		.dvd (ma_s2),
		.dvs (mb_s2),
		.quo (quo)
	);

	// Stage 3: four half-width partial products.
	logic             v_s3, sgn_s3, wide_s3, neg_s3;
	sca_pkg::op_t     op_s3;
	sca_pkg::word_t   ll_s3, lh_s3, hl_s3, hh_s3, as_res_s3, dz_res_s3;
	sca_pkg::status_t as_st_s3, dz_st_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3     <= op_s2;
			sgn_s3    <= sgn_s2;
			wide_s3   <= wide_s2;
			neg_s3    <= neg_s2;
			ll_s3     <= W'(ma_s2[H-1:0]) * W'(mb_s2[H-1:0]);
			lh_s3     <= W'(ma_s2[H-1:0]) * W'(mb_s2[W-1:H]);
			hl_s3     <= W'(ma_s2[W-1:H]) * W'(mb_s2[H-1:0]);
			hh_s3     <= W'(ma_s2[W-1:H]) * W'(mb_s2[W-1:H]);
			as_res_s3 <= as_res_s2;
			as_st_s3  <= as_st_s2;
			dz_res_s3 <= dz_res_s2;
			dz_st_s3  <= dz_st_s2;
		end
	end

	// Stage 4: sum the partial products into the full product.
	logic             v_s4, sgn_s4, wide_s4, neg_s4;
	sca_pkg::op_t     op_s4;
	logic [2*W-1:0]   prod_s4;
	sca_pkg::word_t   as_res_s4, dz_res_s4;
	sca_pkg::status_t as_st_s4, dz_st_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4     <= op_s3;
			sgn_s4    <= sgn_s3;
			wide_s4   <= wide_s3;
			neg_s4    <= neg_s3;
			prod_s4   <= {hh_s3, ll_s3} + {{H{1'b0}}, lh_s3, {H{1'b0}}}
				+ {{H{1'b0}}, hl_s3, {H{1'b0}}};
			as_res_s4 <= as_res_s3;
			as_st_s4  <= as_st_s3;
			dz_res_s4 <= dz_res_s3;
			dz_st_s4  <= dz_st_s3;
		end
	end

	// Stage 5: multiply saturation and the per-operation result choice.
	sca_pkg::word_t   mask4, sbit4, smax4, hi4, lo4, mres4;
	logic             neg4;
	sca_pkg::status_t mst4;
	sca_pkg::side_t   side4;

	always_comb begin
		mask4 = sca_pkg::width_mask(wide_s4);
		sbit4 = sca_pkg::sign_bit(wide_s4);
		smax4 = sbit4 - W'(1);
		hi4   = prod_s4[2*W-1:W];
		lo4   = prod_s4[W-1:0];
		neg4  = neg_s4 && (prod_s4 != '0);
		mres4 = neg4 ? ((-lo4) & mask4) : lo4;
		mst4  = sca_pkg::ST_OK;
		if (sgn_s4) begin
			if (!neg4 && (hi4 != '0 || lo4 > smax4)) begin
				mres4 = smax4;
				mst4  = sca_pkg::ST_OVF_HI;
			end else if (neg4 && (hi4 != '0 || lo4 > sbit4)) begin
				mres4 = sbit4;
				mst4  = sca_pkg::ST_OVF_LO;
			end
		end else if (hi4 != '0 || (lo4 & ~mask4) != '0) begin
			mres4 = mask4;
			mst4  = sca_pkg::ST_OVF_HI;
		end
		side4.valid  = v_s4;
		side4.wide   = wide_s4;
		side4.qneg   = neg_s4;
		side4.is_div = 1'b0;
		case (op_s4)
			sca_pkg::OP_MUL: begin
				side4.res = mres4;
				side4.st  = mst4;
			end
			sca_pkg::OP_DIV: begin
				side4.res    = dz_res_s4;
				side4.st     = dz_st_s4;
				side4.is_div = (dz_st_s4 == sca_pkg::ST_OK);
			end
			default: begin
				side4.res = as_res_s4;
				side4.st  = as_st_s4;
			end
		endcase
	end

	sca_pkg::side_t side_s5;
	sca_pkg::side_t dly_q [0:D-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s5 <= '0;
		end else if (en) begin
			side_s5 <= side4;
		end
	end

	// Delay line that keeps the side data in step with the divider.
	for (genvar j = 0; j < D; j++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dly_q[j] <= '0;
			end else if (en) begin
				dly_q[j] <= (j == 0) ? side_s5 : dly_q[(j == 0) ? 0 : j-1];
			end
		end
	end

	// Final stage: sign the quotient and apply the error mode.
	sca_pkg::side_t   se;
	sca_pkg::word_t   fres;
	sca_pkg::status_t fst;

	always_comb begin
		se   = dly_q[D-1];
		fres = se.res;
		fst  = se.st;
		if (se.is_div) begin
			fres = (se.qneg ? (-quo) : quo) & sca_pkg::width_mask(se.wide);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= se.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= fres;
			status_q <= (mode_q == sca_pkg::MODE_SILENT) ? sca_pkg::ST_OK : fst;
			fatal_q  <= (mode_q >= sca_pkg::MODE_TRAP) && (fst != sca_pkg::ST_OK);
			wide_q   <= se.wide;
		end
	end

	// Checks on the output beats and on the hold during a stall.
	`ASSERT_SAME(a_fatal_has_status, out_valid_q && fatal_q, status_q != sca_pkg::ST_OK)
	`ASSERT_SAME(a_narrow_zero_ext, out_valid_q && !wide_q,
		result_q[W-1:sca_pkg::NARROW] == '0)
	`ASSERT_NEXT(a_stall_holds_line, in_stall, $stable(out_valid_q) && $stable(result_q)
		&& $stable(status_q) && $stable(fatal_q) && $stable(se.valid))

endmodule

`default_nettype wire
